FILE: rtl/ris_pkg.sv
// shared types for the record insertion sorter: stored record, fsm states,
// controller/datapath command and status groups. no dependencies.
`default_nettype none

package ris_pkg;

  localparam int unsigned AgeW = 8;
  localparam int unsigned InitW = 8;
  localparam int unsigned IdxW = 4;

  typedef struct packed {
    logic [AgeW-1:0]  age;
    logic [InitW-1:0] init_ch;
    logic [IdxW-1:0]  idx;
  } rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT_RD,
    ST_EMIT_LD
  } ris_state_e;

  typedef struct packed {
    logic in_ready;
    logic shift;
    logic place;
    logic emit_rd;
    logic load_out;
  } ris_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic full;
    logic last_pend;
    logic pos_zero;
    logic greater;
    logic out_free;
    logic emit_last;
  } ris_sts_t;

endpackage

`default_nettype wire

FILE: rtl/ris_in_if.sv
// input channel of the record sorter: valid/ready plus one record item.
// no dependencies.
`default_nettype none

interface ris_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] age;
  logic [7:0] name_initial;
  logic       last_item;

  modport source (output valid, age, name_initial, last_item, input ready);
  modport sink (input valid, age, name_initial, last_item, output ready);
endinterface

`default_nettype wire

FILE: rtl/ris_out_if.sv
// output channel of the record sorter: valid/ready plus one sorted item.
// no dependencies.
`default_nettype none

interface ris_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sorted_age;
  logic [7:0] sorted_initial;
  logic [3:0] arrival_index;
  logic       end_of_run;
  logic       overflowed;

  modport source (output valid, sorted_age, sorted_initial, arrival_index, end_of_run,
                  overflowed, input ready);
  modport sink (input valid, sorted_age, sorted_initial, arrival_index, end_of_run,
                overflowed, output ready);
endinterface

`default_nettype wire

FILE: rtl/ris_ctrl.sv
// sequencing fsm of the record sorter: load, insertion search, sorted readout.
// depends on ris_pkg.
`default_nettype none

module ris_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  ris_pkg::ris_sts_t  sts_i,
  output ris_pkg::ris_cmd_t  cmd_o
);
  import ris_pkg::*;

  ris_state_e state_q, state_d;
  logic       fire;

  assign fire = sts_i.in_valid && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          priority if (!sts_i.full) state_d = ST_SEARCH;
          else if (sts_i.in_last)   state_d = ST_EMIT_RD;
          else                      state_d = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (sts_i.pos_zero || !sts_i.greater) begin
          state_d = sts_i.last_pend ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (sts_i.out_free) begin
          state_d = sts_i.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:    cmd_o.in_ready = 1'b1;
      ST_SEARCH: begin
        // move the stored record up while it sorts after the new one
        if (!sts_i.pos_zero && sts_i.greater) cmd_o.shift = 1'b1;
        else                                  cmd_o.place = 1'b1;
      end
      ST_EMIT_RD: cmd_o.emit_rd = 1'b1;
      ST_EMIT_LD: cmd_o.load_out = sts_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ris_dp.sv
// datapath of the record sorter: record store memory, counters, insert
// position, readout index and output register. depends on ris_pkg and the
// channel interfaces.
`default_nettype none

module ris_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ris_in_if.sink             in_i,
  ris_out_if.source          out_o,
  input  ris_pkg::ris_cmd_t  cmd_i,
  output ris_pkg::ris_sts_t  sts_o
);
  import ris_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rec_t           mem [DEPTH];
  rec_t           rd_q;
  rec_t           new_q;
  rec_t           wr_rec;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  pos_q;
  logic [AW-1:0]  k_q;
  logic [CW-1:0]  count_q;
  logic           ovf_q;
  logic           last_q;
  logic           in_fire;
  logic           full;
  logic           emit_last;
  logic           mem_we;
  logic           mem_re;
  logic [31:0]    cnt_ext;

  logic           out_valid_q;
  logic [7:0]     out_age_q;
  logic [7:0]     out_init_q;
  logic [3:0]     out_idx_q;
  logic           out_end_q;
  logic           out_ovf_q;

  assign in_i.ready = cmd_i.in_ready;
  assign in_fire    = in_i.valid && cmd_i.in_ready;
  assign full       = (count_q == CW'(DEPTH));
  assign emit_last  = ((CW'(k_q) + CW'(1)) == count_q);
  assign cnt_ext    = 32'(count_q);

  assign sts_o.in_valid  = in_i.valid;
  assign sts_o.in_last   = in_i.last_item;
  assign sts_o.full      = full;
  assign sts_o.last_pend = last_q;
  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.greater   = {rd_q.age, rd_q.init_ch} > {new_q.age, new_q.init_ch};
  assign sts_o.out_free  = !out_valid_q || out_o.ready;
  assign sts_o.emit_last = emit_last;

  // read port address: the entry below the insert point, or the readout index
  always_comb begin
    priority if (in_fire)     rd_addr = count_q[AW-1:0] - AW'(1);
    else if (cmd_i.shift)     rd_addr = pos_q - AW'(2);
    else                      rd_addr = k_q;
  end

  assign mem_we = cmd_i.shift || cmd_i.place;
  assign mem_re = in_fire || cmd_i.shift || cmd_i.emit_rd;
  assign wr_rec = cmd_i.shift ? rd_q : new_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[pos_q] <= wr_rec;
    end
    // read register holds its entry while the output register waits
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !full) begin
      new_q.age     <= in_i.age;
      new_q.init_ch <= in_i.name_initial;
      new_q.idx     <= cnt_ext[3:0];
      pos_q         <= count_q[AW-1:0];
    end else if (cmd_i.shift) begin
      pos_q <= pos_q - AW'(1);
    end
    if (cmd_i.load_out) begin
      out_age_q  <= rd_q.age;
      out_init_q <= rd_q.init_ch;
      out_idx_q  <= rd_q.idx;
      out_end_q  <= emit_last;
      out_ovf_q  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        last_q <= in_i.last_item;
        if (full) ovf_q <= 1'b1;
      end
      if (cmd_i.place) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.load_out) begin
        if (emit_last) begin
          // set done: start an empty one
          count_q <= '0;
          ovf_q   <= 1'b0;
          last_q  <= 1'b0;
          k_q     <= '0;
        end else begin
          k_q <= k_q + AW'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.sorted_age     = out_age_q;
  assign out_o.sorted_initial = out_init_q;
  assign out_o.arrival_index  = out_idx_q;
  assign out_o.end_of_run     = out_end_q;
  assign out_o.overflowed     = out_ovf_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("record count beyond store depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_o.ready))
    else $error("output register overwritten while an item waits");

  a_shift_not_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (pos_q != '0) && !cmd_i.place)
    else $error("shift at bottom of store or together with place");

  a_place_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.place && !cmd_i.load_out) |=> count_q == $past(count_q) + CW'(1))
    else $error("placed record not counted");
`endif

endmodule

`default_nettype wire

FILE: rtl/record_insertion_sort.sv
// insertion of one record: accepted in idle, then a search moves the s stored records
// with a greater key (0 .. DEPTH-1) up one place each and places the item; no new item
// is accepted until it ends. a last item adds readout of each record through the output
// register. full store: the item is dropped. the store read/write port sets the pace.
// reset (rst_ni, async, active low) empties the set; store contents are not cleared.
// top level: controller and datapath. depends on ris_pkg and the channel interfaces.
`default_nettype none

module record_insertion_sort #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ris_in_if.sink    in_i,
  ris_out_if.source out_o
);
  import ris_pkg::*;

  ris_cmd_t cmd;
  ris_sts_t sts;

  ris_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ris_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire
